// ===== design/mlpf_pkg.sv =====
// ============================================================================
// mlpf_pkg
// Shared types, codes and default sizes of the multi-level priority FIFO.
// ============================================================================
package mlpf_pkg;

    // default sizes
    localparam int LEVELS_DEF     = 5;
    localparam int LINES_DEF      = 4;
    localparam int LINE_SLOTS_DEF = 64;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // request kinds at the port
    localparam logic [1:0] REQ_INSERT     = 2'd0;
    localparam logic [1:0] REQ_INSERT_DEF = 2'd1;
    localparam logic [1:0] REQ_DEQ_HIGH   = 2'd2;
    localparam logic [1:0] REQ_DEQ_LOW    = 2'd3;

    // classified operations
    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_BAD_PRIO = 2'd1;
    localparam logic [1:0] OP_DEQ_HIGH = 2'd2;
    localparam logic [1:0] OP_DEQ_LOW  = 2'd3;

    // result status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_BAD_PRIO = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  level;
        logic [31:0] content;
    } mlpf_cmd_t;

endpackage

// ===== design/mlpf_front.sv =====
// ============================================================================
// mlpf_front
// Accepts requests and classifies them into queue commands.
// ============================================================================
module mlpf_front #(
    parameter int LEVELS = mlpf_pkg::LEVELS_DEF
) (
    input  logic              start,
    input  logic [1:0]        req_type,
    input  logic [2:0]        priority_req,
    input  logic [31:0]       content,
    input  logic              q_full,
    output logic              busy,
    output logic              push,
    output mlpf_pkg::mlpf_cmd_t cmd
);
    import mlpf_pkg::*;

    localparam logic [2:0] DEFAULT_LEVEL = 3'(LEVELS / 2);

    assign busy = q_full;
    assign push = start & ~q_full;

    always_comb
    begin
        cmd.content = content;
        cmd.level   = priority_req;
        cmd.op      = OP_INSERT;
        unique case (req_type)
            REQ_INSERT:
            begin
                if (4'(priority_req) >= 4'(LEVELS))
                begin
                    cmd.op = OP_BAD_PRIO;
                end
            end
            REQ_INSERT_DEF:
            begin
                cmd.level = DEFAULT_LEVEL;
            end
            REQ_DEQ_HIGH:
            begin
                cmd.op = OP_DEQ_HIGH;
            end
            REQ_DEQ_LOW:
            begin
                cmd.op = OP_DEQ_LOW;
            end
            default:
            begin
                cmd.op = OP_INSERT;
            end
        endcase
    end

endmodule

// ===== design/mlpf_cmd_queue.sv =====
// ============================================================================
// mlpf_cmd_queue
// Short command FIFO between the front and the back.
// ============================================================================
module mlpf_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mlpf_pkg::mlpf_cmd_t push_cmd,
    input  logic                pop,
    output logic                full,
    output logic                not_empty,
    output mlpf_pkg::mlpf_cmd_t head_cmd
);
    import mlpf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mlpf_cmd_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/mlpf_back.sv =====
// ============================================================================
// mlpf_back
// Executes queued commands: per-level FIFO pointers, counts and entry store.
// ============================================================================
module mlpf_back #(
    parameter int LEVELS     = mlpf_pkg::LEVELS_DEF,
    parameter int LINES      = mlpf_pkg::LINES_DEF,
    parameter int LINE_SLOTS = mlpf_pkg::LINE_SLOTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_not_empty,
    input  mlpf_pkg::mlpf_cmd_t q_cmd,
    output logic                pop,
    output logic                done,
    output logic [1:0]          status,
    output logic [31:0]         content_out,
    output logic [2:0]          served_level,
    output logic [11:0]         held_count
);
    import mlpf_pkg::*;

    localparam int LEVEL_CAP = LINES * LINE_SLOTS;
    localparam int MEM_DEPTH = LEVELS * LEVEL_CAP;
    localparam int LIDX_W    = $clog2(LEVELS);
    localparam int PTR_W     = $clog2(LEVEL_CAP);
    localparam int CNT_W     = $clog2(LEVEL_CAP + 1);
    localparam int TOT_W     = $clog2(MEM_DEPTH + 1);
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_READ = 1'b1;

    logic              state_reg, state_next;
    logic [PTR_W-1:0]  head_reg [LEVELS];
    logic [PTR_W-1:0]  head_next [LEVELS];
    logic [PTR_W-1:0]  tail_reg [LEVELS];
    logic [PTR_W-1:0]  tail_next [LEVELS];
    logic [CNT_W-1:0]  lvl_cnt_reg [LEVELS];
    logic [CNT_W-1:0]  lvl_cnt_next [LEVELS];
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [2:0]        pend_level_reg, pend_level_next;

    logic [31:0]       entry_mem [MEM_DEPTH];
    logic [31:0]       rd_data_reg;
    logic              mem_wr, mem_rd;
    logic [ADDR_W-1:0] mem_addr;

    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       content_reg, content_next;
    logic [2:0]        level_reg, level_next;
    logic [11:0]       count_reg, count_next;

    logic [LEVELS-1:0] nonempty;
    logic [LIDX_W-1:0] hi_idx, lo_idx, sel_idx, ins_idx;

    // level scan over non-empty flags
    always_comb
    begin
        hi_idx = '0;
        lo_idx = '0;
        for (int i = 0; i < LEVELS; i++)
        begin
            nonempty[i] = (lvl_cnt_reg[i] != '0);
        end
        for (int i = 0; i < LEVELS; i++)
        begin
            if (nonempty[i])
            begin
                hi_idx = LIDX_W'(i);
            end
        end
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (nonempty[i])
            begin
                lo_idx = LIDX_W'(i);
            end
        end
    end

    assign ins_idx = q_cmd.level[LIDX_W-1:0];
    assign sel_idx = (q_cmd.op == OP_DEQ_HIGH) ? hi_idx : lo_idx;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        lvl_cnt_next    = lvl_cnt_reg;
        total_next      = total_reg;
        pend_level_next = pend_level_reg;
        pop             = 1'b0;
        mem_wr          = 1'b0;
        mem_rd          = 1'b0;
        mem_addr        = '0;
        done_next       = 1'b0;
        status_next     = ST_OK;
        content_next    = '0;
        level_next      = '0;
        count_next      = 12'(total_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    pop = 1'b1;
                    case (q_cmd.op)
                        OP_BAD_PRIO:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_BAD_PRIO;
                            level_next  = q_cmd.level;
                        end
                        OP_INSERT:
                        begin
                            done_next  = 1'b1;
                            level_next = q_cmd.level;
                            if (lvl_cnt_reg[ins_idx] == CNT_W'(LEVEL_CAP))
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_wr   = 1'b1;
                                mem_addr = ADDR_W'(ins_idx) * ADDR_W'(LEVEL_CAP)
                                         + ADDR_W'(tail_reg[ins_idx]);
                                tail_next[ins_idx] =
                                    (tail_reg[ins_idx] == PTR_W'(LEVEL_CAP - 1)) ?
                                    '0 : tail_reg[ins_idx] + 1'b1;
                                lvl_cnt_next[ins_idx] = lvl_cnt_reg[ins_idx] + 1'b1;
                                total_next = total_reg + 1'b1;
                                count_next = 12'(total_next);
                            end
                        end
                        default:
                        begin
                            if (nonempty == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                mem_rd   = 1'b1;
                                mem_addr = ADDR_W'(sel_idx) * ADDR_W'(LEVEL_CAP)
                                         + ADDR_W'(head_reg[sel_idx]);
                                head_next[sel_idx] =
                                    (head_reg[sel_idx] == PTR_W'(LEVEL_CAP - 1)) ?
                                    '0 : head_reg[sel_idx] + 1'b1;
                                lvl_cnt_next[sel_idx] = lvl_cnt_reg[sel_idx] - 1'b1;
                                total_next      = total_reg - 1'b1;
                                pend_level_next = 3'(sel_idx);
                                state_next      = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // read data is in rd_data_reg; counts already updated
                done_next    = 1'b1;
                status_next  = ST_OK;
                content_next = rd_data_reg;
                level_next   = pend_level_reg;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            done_reg  <= 1'b0;
            for (int i = 0; i < LEVELS; i++)
            begin
                head_reg[i]    <= '0;
                tail_reg[i]    <= '0;
                lvl_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            done_reg    <= done_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            lvl_cnt_reg <= lvl_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_level_reg <= pend_level_next;
        if (done_next)
        begin
            status_reg  <= status_next;
            content_reg <= content_next;
            level_reg   <= level_next;
            count_reg   <= count_next;
        end
    end

    // entry store
    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            entry_mem[mem_addr] <= q_cmd.content;
        end
        if (mem_rd)
        begin
            rd_data_reg <= entry_mem[mem_addr];
        end
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign content_out  = content_reg;
    assign served_level = level_reg;
    assign held_count   = count_reg;

endmodule

// ===== design/multi_level_priority_fifo.sv =====
// ============================================================================
// multi_level_priority_fifo
// One FIFO of 32-bit handles per priority level, with highest/lowest dequeue.
// ============================================================================
//
//  channel   handshake                 payload
//  --------  ------------------------  -------------------------------------
//  request   start, busy (start&!busy) req_type, priority_req, content
//  result    done (one-cycle strobe)   status, content_out, served_level,
//                                      held_count
//
// With the back end free, an insert, a rejected insert or an empty dequeue
// goes from acceptance through the command queue and the result register to
// done; a successful dequeue also goes through the registered read of the
// entry store. A command queued behind such a dequeue waits for that read.
// The back end serves one transaction at a time and pops no command meanwhile.
// Reset (rst_n low, async) empties all levels; no clearing pass is needed.
// busy rises while the 2-entry command queue is full. The receiver cannot
// stall: every done strobe is one result, in request order.
//
module multi_level_priority_fifo #(
    parameter int LEVELS     = mlpf_pkg::LEVELS_DEF,
    parameter int LINES      = mlpf_pkg::LINES_DEF,
    parameter int LINE_SLOTS = mlpf_pkg::LINE_SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [2:0]  priority_req,
    input  logic [31:0] content,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] content_out,
    output logic [2:0]  served_level,
    output logic [11:0] held_count
);
    import mlpf_pkg::*;

    // front -> queue
    logic      push;
    mlpf_cmd_t push_cmd;
    logic      q_full;

    // queue -> back
    logic      pop;
    logic      q_not_empty;
    mlpf_cmd_t head_cmd;

    // front end: classification of each request transaction
    mlpf_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .start        (start),
        .req_type     (req_type),
        .priority_req (priority_req),
        .content      (content),
        .q_full       (q_full),
        .busy         (busy),
        .push         (push),
        .cmd          (push_cmd)
    );

    // decoupling queue
    mlpf_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_cmd  (head_cmd)
    );

    // back end: level FIFOs, entry store and result register
    mlpf_back #(
        .LEVELS     (LEVELS),
        .LINES      (LINES),
        .LINE_SLOTS (LINE_SLOTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_cmd        (head_cmd),
        .pop          (pop),
        .done         (done),
        .status       (status),
        .content_out  (content_out),
        .served_level (served_level),
        .held_count   (held_count)
    );

endmodule
